// File: design/bpa_pkg.sv
// Shared types, codes and helpers for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int MAX_ORDER_DEF   = 10;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int ADDR_W          = 20;

  // request action codes
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_REF     = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_REQ  = 3'd1;
  localparam logic [2:0] ST_NO_FREE  = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR = 3'd3;
  localparam logic [2:0] ST_COUNT    = 3'd4;

  // configuration register byte address
  localparam logic [1:0] REG_BASE_PAGE = 2'd0;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] num_pages;
    logic [ADDR_W-1:0] page_address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic              page_freed;
    logic [4:0]        merged_order;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SPLIT,
    S_CNT_RD,
    S_CNT_WR,
    S_REL_RD,
    S_REL_CHK,
    S_COV_RD,
    S_COV_CHK,
    S_MRG_RD,
    S_MRG_CHK,
    S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SRCH_RD,
    OP_SRCH_NEXT,
    OP_TAKE,
    OP_SPLIT,
    OP_CNT_START,
    OP_CNT_INC,
    OP_CNT_DEC,
    OP_COV_RD,
    OP_COV_NEXT,
    OP_MRG_START,
    OP_MRG_RD,
    OP_MRG_STEP,
    OP_MRG_END,
    OP_FAIL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic [1:0] act;
    logic bad_req;
    logic bad_addr;
    logic map_bit;
    logic srch_end;
    logic k_is_max;
    logic k_eq_need;
    logic cnt_last;
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } flags_t;

  // number of significant bits of a request size minus one
  function automatic logic [4:0] bit_length(input logic [ADDR_W-1:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < ADDR_W; i++) begin
      if (v[i]) r = 5'(i + 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/bpa_dp.sv
// Datapath: free map and count memories, working registers and result register.
`default_nettype none
module bpa_dp #(
  parameter int MAX_ORDER_P = bpa_pkg::MAX_ORDER_DEF,
  parameter int COUNT_WIDTH = bpa_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bpa_pkg::cmd_t                 cmd,
  input  wire bpa_pkg::req_t                 req,
  input  wire logic [bpa_pkg::ADDR_W-1:0]    base_page,
  input  wire logic                          rsp_stall,
  output bpa_pkg::flags_t                    flags,
  output logic                               rsp_valid,
  output bpa_pkg::rsp_t                      rsp
);
  import bpa_pkg::*;

  localparam int MW        = MAX_ORDER_P;
  localparam int NODE_W    = MW + 1;
  localparam int MAP_NODES = (2 << MW) - 1;
  localparam int PAGES     = 1 << MW;
  localparam logic [4:0] MAX_K = 5'(MW);
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic                    map_mem [MAP_NODES];
  logic [COUNT_WIDTH-1:0]  cnt_mem [PAGES];

  logic [NODE_W-1:0]      clr;
  logic [1:0]             act;
  logic                   bad_req;
  logic                   bad_addr;
  logic [4:0]             need;
  logic [4:0]             k;
  logic [MW-1:0]          b;
  logic [MW-1:0]          off;
  logic [MW-1:0]          pg;
  logic [2:0]             st;
  logic [ADDR_W-1:0]      addr;
  logic                   freed;
  logic [4:0]             order;
  logic                   map_q;
  logic [COUNT_WIDTH-1:0] cnt_q;

  // heap index of block bb at order kk
  function automatic logic [NODE_W-1:0] node(input logic [4:0] kk, input logic [MW-1:0] bb);
    return ((NODE_W'(1) << (MAX_K - kk)) - NODE_W'(1)) + NODE_W'(bb);
  endfunction

  logic [ADDR_W-1:0] in_off;
  logic [4:0]        in_len;
  logic [MW-1:0]     last_b;
  logic [MW-1:0]     need_mask;
  logic [MW-1:0]     b_split;
  logic [4:0]        k_dn;
  logic [NODE_W-1:0] map_ra;
  logic              map_we;
  logic [NODE_W-1:0] map_wa;
  logic              map_wd;
  logic              cnt_we;
  logic [MW-1:0]     cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;
  logic              out_free;

  assign in_off    = req.page_address - base_page;
  assign in_len    = bit_length(req.num_pages - ADDR_W'(1));
  assign last_b    = MW'((NODE_W'(1) << (MAX_K - k)) - NODE_W'(1));
  assign need_mask = MW'((NODE_W'(1) << need) - NODE_W'(1));
  assign k_dn      = k - 5'd1;
  assign b_split   = (b << 1) | MW'(1);
  assign out_free  = !rsp_valid || !rsp_stall;

  // select map read address
  always_comb begin
    case (cmd.op)
      OP_SRCH_RD: map_ra = node(k, b);
      OP_COV_RD:  map_ra = node(k, off >> k);
      OP_MRG_RD:  map_ra = node(k, b ^ MW'(1));
      default:    map_ra = '0;
    endcase
  end

  // select memory writes
  always_comb begin
    map_we = 1'b0;
    map_wa = node(k, b);
    map_wd = 1'b0;
    cnt_we = 1'b0;
    cnt_wa = pg;
    cnt_wd = cnt_q;
    case (cmd.op)
      OP_CLEAR: begin
        map_we = (clr != '1);
        map_wa = clr;
        map_wd = (clr == '0);
        cnt_we = !clr[MW];
        cnt_wa = clr[MW-1:0];
        cnt_wd = '0;
      end
      OP_TAKE: begin
        map_we = 1'b1;
      end
      OP_SPLIT: begin
        map_we = 1'b1;
        map_wa = node(k_dn, b_split);
        map_wd = 1'b1;
      end
      OP_MRG_STEP: begin
        map_we = 1'b1;
        map_wa = node(k, b ^ MW'(1));
      end
      OP_MRG_END: begin
        map_we = 1'b1;
        map_wd = 1'b1;
      end
      OP_CNT_INC: begin
        cnt_we = 1'b1;
        cnt_wd = (cnt_q == CMAX) ? CMAX : cnt_q + COUNT_WIDTH'(1);
      end
      OP_CNT_DEC: begin
        cnt_we = 1'b1;
        cnt_wd = cnt_q - COUNT_WIDTH'(1);
      end
      default: ;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[pg];
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr <= clr + NODE_W'(1);
    end
    case (cmd.op)
      OP_LOAD: begin
        act      <= req.action;
        bad_req  <= (req.num_pages == '0) || (in_len > MAX_K);
        bad_addr <= (in_off >> MW) != '0;
        off      <= in_off[MW-1:0];
        pg       <= in_off[MW-1:0];
        need     <= (req.action == ACT_ALLOC) ? in_len : 5'd0;
        k        <= (req.action == ACT_ALLOC) ? in_len : 5'd0;
        b        <= '0;
        st       <= ST_OK;
        addr     <= '0;
        freed    <= 1'b0;
        order    <= '0;
      end
      OP_SRCH_NEXT: begin
        if (b == last_b) begin
          k <= k + 5'd1;
          b <= '0;
        end else begin
          b <= b + MW'(1);
        end
      end
      OP_SPLIT: begin
        k <= k_dn;
        b <= b << 1;
      end
      OP_CNT_START: begin
        pg    <= b << need;
        addr  <= base_page + ADDR_W'(b << need);
        order <= need;
      end
      OP_CNT_INC: begin
        if (cnt_q == CMAX) st <= ST_COUNT;
        pg <= pg + MW'(1);
      end
      OP_CNT_DEC: k <= 5'd0;
      OP_COV_NEXT: k <= k + 5'd1;
      OP_MRG_START: begin
        k <= 5'd0;
        b <= off;
      end
      OP_MRG_STEP: begin
        k <= k + 5'd1;
        b <= b >> 1;
      end
      OP_MRG_END: begin
        freed <= 1'b1;
        order <= k;
      end
      OP_FAIL: st <= cmd.code;
      default: ;
    endcase
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.op == OP_EMIT) begin
      rsp.status        <= st;
      rsp.block_address <= addr;
      rsp.page_freed    <= freed;
      rsp.merged_order  <= order;
    end
  end

  // status toward the controller
  always_comb begin
    flags.clr_done  = (clr == '1);
    flags.act       = act;
    flags.bad_req   = bad_req;
    flags.bad_addr  = bad_addr;
    flags.map_bit   = map_q;
    flags.srch_end  = (b == last_b) && (k == MAX_K);
    flags.k_is_max  = (k == MAX_K);
    flags.k_eq_need = (k == need);
    flags.cnt_last  = (pg & need_mask) == need_mask;
    flags.cnt_zero  = (cnt_q == '0);
    flags.cnt_one   = (cnt_q == COUNT_WIDTH'(1));
    flags.out_free  = out_free;
  end

endmodule
`default_nettype wire

// File: design/bpa_ctrl.sv
// Controller: sequences clearing, search, split, count update and merge steps.
`default_nettype none
module bpa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire bpa_pkg::flags_t flags,
  output bpa_pkg::cmd_t        cmd
);
  import bpa_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (flags.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_EMIT;
        cmd.op     = OP_FAIL;
        if (flags.act == ACT_ALLOC) begin
          if (flags.bad_req) begin
            cmd.code = ST_BAD_REQ;
          end else begin
            cmd.op     = OP_NONE;
            state_next = S_SRCH_RD;
          end
        end else if (flags.act == ACT_RELEASE || flags.act == ACT_REF) begin
          if (flags.bad_addr) begin
            cmd.code = ST_BAD_ADDR;
          end else begin
            cmd.op     = OP_NONE;
            state_next = (flags.act == ACT_RELEASE) ? S_REL_RD : S_CNT_RD;
          end
        end else begin
          cmd.code = ST_BAD_REQ;
        end
      end
      S_SRCH_RD: begin
        cmd.op     = OP_SRCH_RD;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (flags.map_bit) begin
          cmd.op     = OP_TAKE;
          state_next = S_SPLIT;
        end else if (flags.srch_end) begin
          cmd.op     = OP_FAIL;
          cmd.code   = ST_NO_FREE;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_SRCH_NEXT;
          state_next = S_SRCH_RD;
        end
      end
      S_SPLIT: begin
        if (flags.k_eq_need) begin
          cmd.op     = OP_CNT_START;
          state_next = S_CNT_RD;
        end else begin
          cmd.op = OP_SPLIT;
        end
      end
      S_CNT_RD: state_next = S_CNT_WR;
      S_CNT_WR: begin
        cmd.op     = OP_CNT_INC;
        state_next = flags.cnt_last ? S_EMIT : S_CNT_RD;
      end
      S_REL_RD: state_next = S_REL_CHK;
      S_REL_CHK: begin
        if (flags.cnt_zero) begin
          cmd.op     = OP_FAIL;
          cmd.code   = ST_COUNT;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_CNT_DEC;
          state_next = flags.cnt_one ? S_COV_RD : S_EMIT;
        end
      end
      S_COV_RD: begin
        cmd.op     = OP_COV_RD;
        state_next = S_COV_CHK;
      end
      S_COV_CHK: begin
        if (flags.map_bit) begin
          state_next = S_EMIT;
        end else if (flags.k_is_max) begin
          cmd.op     = OP_MRG_START;
          state_next = S_MRG_RD;
        end else begin
          cmd.op     = OP_COV_NEXT;
          state_next = S_COV_RD;
        end
      end
      S_MRG_RD: begin
        if (flags.k_is_max) begin
          cmd.op     = OP_MRG_END;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_MRG_RD;
          state_next = S_MRG_CHK;
        end
      end
      S_MRG_CHK: begin
        if (flags.map_bit) begin
          cmd.op     = OP_MRG_STEP;
          state_next = S_MRG_RD;
        end else begin
          cmd.op     = OP_MRG_END;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (flags.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/buddy_page_allocator_refcount_top.sv
// Buddy page allocator with per-page reference counts: top level and register port.
//
// Manages 2^MAX_ORDER_P pages from base_page, one request at a time. After
// reset a clearing pass runs over the free map and count memories before the
// first request is taken. Each step is paced by the registered read of the
// free map and count memories: an allocate scans free-map nodes, splits and
// updates the count of each page of the block; a reference updates one count
// and a release decrements one, then may check cover and merge buddies.
// A finished result waits in an output register for the consumer.
`default_nettype none
module buddy_page_allocator_refcount_top #(
  parameter int MAX_ORDER_P = bpa_pkg::MAX_ORDER_DEF,
  parameter int COUNT_WIDTH = bpa_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bpa_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bpa_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bpa_pkg::*;

  logic [ADDR_W-1:0] base_page;
  cmd_t              cmd;
  flags_t            flags;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BASE_PAGE) ? {{(32-ADDR_W){1'b0}}, base_page} : '0;

  // write base page register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_page <= '0;
    end else if (psel && penable && pwrite && paddr == REG_BASE_PAGE) begin
      base_page <= pwdata[ADDR_W-1:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  bpa_dp #(
    .MAX_ORDER_P (MAX_ORDER_P),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .base_page (base_page),
    .rsp_stall (rsp_stall),
    .flags     (flags),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// File: bench/buddy_page_allocator_refcount_top_test.sv
// Self-checking testbench for the buddy page allocator with per-page reference counts.
module buddy_page_allocator_refcount_top_test;
  import bpa_pkg::*;

  localparam int MO = MAX_ORDER_DEF;
  localparam int PAGES = 1 << MO;
  localparam int NODES = (2 << MO) - 1;
  localparam logic [COUNT_WIDTH_DEF-1:0] CNT_MAX = '1;
  localparam logic [1:0] ACT_BOGUS = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  buddy_page_allocator_refcount_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of allocator state
  logic [ADDR_W-1:0] shadow_base;
  logic free_map [NODES];
  logic [COUNT_WIDTH_DEF-1:0] shadow_cnt [PAGES];

  rsp_t pending_rsp [$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  int hold_ask = 0;
  int hold_left = 0;

  function automatic int map_node(int k, int b);
    return ((1 << (MO - k)) - 1) + b;
  endfunction

  function automatic rsp_t mk_rsp(logic [2:0] st, logic [ADDR_W-1:0] a, logic f, int o);
    rsp_t r;
    r.status = st;
    r.block_address = a;
    r.page_freed = f;
    r.merged_order = 5'(o);
    return r;
  endfunction

  // compute the result of one request and advance the shadow state
  function automatic rsp_t predict_page_op(req_t r);
    int need, k, b, blocks, first;
    logic [ADDR_W-1:0] v, off;
    logic [2:0] st;
    bit found, covered;
    off = r.page_address - shadow_base;
    if (r.action == ACT_ALLOC) begin
      if (r.num_pages == 0) return mk_rsp(ST_BAD_REQ, '0, 1'b0, 0);
      v = r.num_pages - ADDR_W'(1);
      need = 0;
      while (v != 0) begin
        v = v >> 1;
        need++;
      end
      if (need > MO) return mk_rsp(ST_BAD_REQ, '0, 1'b0, 0);
      found = 0;
      b = 0;
      for (k = need; k <= MO; k++) begin
        blocks = 1 << (MO - k);
        for (b = 0; b < blocks; b++) if (free_map[map_node(k, b)]) begin
          found = 1;
          break;
        end
        if (found) break;
      end
      if (!found) return mk_rsp(ST_NO_FREE, '0, 1'b0, 0);
      free_map[map_node(k, b)] = 1'b0;
      while (k > need) begin
        k--;
        b = b << 1;
        free_map[map_node(k, b + 1)] = 1'b1;
      end
      first = b << need;
      st = ST_OK;
      for (int i = 0; i < (1 << need); i++) begin
        if (shadow_cnt[first + i] == CNT_MAX) st = ST_COUNT;
        else shadow_cnt[first + i]++;
      end
      return mk_rsp(st, shadow_base + ADDR_W'(first), 1'b0, need);
    end
    if (r.action != ACT_RELEASE && r.action != ACT_REF) return mk_rsp(ST_BAD_REQ, '0, 1'b0, 0);
    if (off >= PAGES) return mk_rsp(ST_BAD_ADDR, '0, 1'b0, 0);
    if (r.action == ACT_REF) begin
      if (shadow_cnt[off] == CNT_MAX) return mk_rsp(ST_COUNT, '0, 1'b0, 0);
      shadow_cnt[off]++;
      return mk_rsp(ST_OK, '0, 1'b0, 0);
    end
    if (shadow_cnt[off] == 0) return mk_rsp(ST_COUNT, '0, 1'b0, 0);
    shadow_cnt[off]--;
    if (shadow_cnt[off] != 0) return mk_rsp(ST_OK, '0, 1'b0, 0);
    covered = 0;
    for (k = 0; k <= MO; k++) if (free_map[map_node(k, int'(off) >> k)]) covered = 1;
    if (covered) return mk_rsp(ST_OK, '0, 1'b0, 0);
    k = 0;
    b = int'(off);
    while (k < MO && free_map[map_node(k, b ^ 1)]) begin
      free_map[map_node(k, b ^ 1)] = 1'b0;
      b = b >> 1;
      k++;
    end
    free_map[map_node(k, b)] = 1'b1;
    return mk_rsp(ST_OK, '0, 1'b1, k);
  endfunction

  // offer one request, idling at random, and record its result once taken
  task automatic send_request(req_t r, bit fixed, rsp_t fixed_rsp);
    rsp_t p;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    p = predict_page_op(r);
    pending_rsp.push_back(fixed ? fixed_rsp : p);
  endtask

  task automatic send_checked(req_t r);
    send_request(r, 1'b0, '0);
  endtask

  // drop valid and wait until every result has come back
  task automatic drain;
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= REG_BASE_PAGE;
    pwdata <= {12'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[ADDR_W-1:0] !== v) begin
      $error("base_page readback: expected %h, actual %h", v, prdata[ADDR_W-1:0]);
      failed = 1'b1;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    shadow_base = v;
  endtask

  function automatic req_t mk_req(logic [1:0] a, logic [ADDR_W-1:0] n, logic [ADDR_W-1:0] pa);
    req_t r;
    r.action = a;
    r.num_pages = n;
    r.page_address = pa;
    return r;
  endfunction

  // random traffic: mostly allocations and releases of live pages
  task automatic random_requests(int n);
    req_t r;
    int pick, s, off;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      r = mk_req(ACT_ALLOC, ADDR_W'($urandom), ADDR_W'($urandom));
      if (pick < 38) begin
        s = $urandom_range(99);
        if (s < 85) r.num_pages = ADDR_W'($urandom_range(1, 16));
        else if (s < 95) r.num_pages = ADDR_W'($urandom_range(17, PAGES));
        else if (s < 97) r.num_pages = '0;
      end else if (pick < 80) begin
        r.action = ACT_RELEASE;
        off = $urandom_range(PAGES - 1);
        if ($urandom_range(9) < 8) begin
          s = off;
          for (int j = 0; j < PAGES; j++) if (shadow_cnt[(s + j) % PAGES] != 0) begin
            off = (s + j) % PAGES;
            break;
          end
        end
        r.page_address = shadow_base + ADDR_W'(off);
      end else if (pick < 90) begin
        r.action = ACT_REF;
        r.page_address = shadow_base + ADDR_W'($urandom_range(PAGES - 1));
      end else begin
        r.action = 2'($urandom);
      end
      send_checked(r);
    end
  endtask

  typedef struct {
    req_t r;
    bit fixed;
    rsp_t e;
  } stim_row_t;

  // consumer side: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 23);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result %p", rsp);
        failed = 1'b1;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp.status);
          failed = 1'b1;
        end
        if (rsp.block_address !== e.block_address) begin
          $error("block_address: expected %h, actual %h", e.block_address, rsp.block_address);
          failed = 1'b1;
        end
        if (rsp.page_freed !== e.page_freed) begin
          $error("page_freed: expected %0d, actual %0d", e.page_freed, rsp.page_freed);
          failed = 1'b1;
        end
        if (rsp.merged_order !== e.merged_order) begin
          $error("merged_order: expected %0d, actual %0d", e.merged_order, rsp.merged_order);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #400000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    rsp_t none;
    none = '0;
    shadow_base = '0;
    for (int i = 0; i < NODES; i++) free_map[i] = (i == 0);
    for (int i = 0; i < PAGES; i++) shadow_cnt[i] = '0;

    rows = '{
      '{mk_req(ACT_ALLOC, 20'd0, 20'd0), 1, mk_rsp(ST_BAD_REQ, 0, 0, 0)},
      '{mk_req(ACT_ALLOC, 20'hFFFFF, 20'hFFFFF), 1, mk_rsp(ST_BAD_REQ, 0, 0, 0)},
      '{mk_req(ACT_ALLOC, 20'd1025, 20'd0), 1, mk_rsp(ST_BAD_REQ, 0, 0, 0)},
      '{mk_req(ACT_BOGUS, 20'd1, 20'd1), 1, mk_rsp(ST_BAD_REQ, 0, 0, 0)},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd5), 1, mk_rsp(ST_COUNT, 0, 0, 0)},
      '{mk_req(ACT_REF, 20'd0, 20'd1024), 1, mk_rsp(ST_BAD_ADDR, 0, 0, 0)},
      '{mk_req(ACT_RELEASE, 20'd0, 20'hFFFFF), 1, mk_rsp(ST_BAD_ADDR, 0, 0, 0)},
      '{mk_req(ACT_ALLOC, 20'd1024, 20'd0), 1, mk_rsp(ST_OK, 0, 0, 10)},
      '{mk_req(ACT_ALLOC, 20'd1, 20'd0), 1, mk_rsp(ST_NO_FREE, 0, 0, 0)},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd0), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd0), 1, mk_rsp(ST_COUNT, 0, 0, 0)},
      '{mk_req(ACT_REF, 20'd0, 20'd0), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd0), 0, none},
      '{mk_req(ACT_ALLOC, 20'd1, 20'd0), 0, none},
      '{mk_req(ACT_REF, 20'd0, 20'd3), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd3), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd3), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd1), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd0), 0, none},
      '{mk_req(ACT_ALLOC, 20'd3, 20'd0), 0, none},
      '{mk_req(ACT_ALLOC, 20'd2, 20'd0), 0, none},
      '{mk_req(ACT_REF, 20'd0, 20'd1023), 0, none},
      '{mk_req(ACT_RELEASE, 20'd0, 20'd1023), 0, none}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_base(20'h0);
    foreach (rows[i]) send_request(rows[i].r, rows[i].fixed, rows[i].e);
    drain();

    write_base(20'hFFC00);
    random_requests(150);
    drain();

    write_base(20'hFFFFF);
    no_idle = 1'b1;
    random_requests(80);
    no_idle = 1'b0;
    drain();

    // long consumer hold-off while requests keep coming
    write_base(ADDR_W'($urandom_range(1, 1022) << MO));
    hold_ask = 3000;
    random_requests(150);
    drain();

    write_base(20'h0);
    random_requests(170);
    drain();

    repeat (200) @(posedge clk);
    if (!failed && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
design/bpa_pkg.sv
design/bpa_dp.sv
design/bpa_ctrl.sv
design/buddy_page_allocator_refcount_top.sv
bench/buddy_page_allocator_refcount_top_test.sv
